### hw/rtl/source_code_lexer_assert.svh
// ----------------------------------------------------------------------------
// Source code lexer assertion macros
// Shared forms for the concurrent checks of the lexer, clocked on the rising
// edge and switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef SOURCE_CODE_LEXER_ASSERT_SVH
`define SOURCE_CODE_LEXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLX_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("source_code_lexer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("source_code_lexer check failed");

`endif

### hw/rtl/slx_pkg.sv
// ----------------------------------------------------------------------------
// Source code lexer package
// Transaction types, token kind codes, limits and the keyword table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slx_pkg;

    localparam longint unsigned MAX_TEXT_LENGTH = 65535;
    localparam logic [15:0] POS_LIMIT =
        (MAX_TEXT_LENGTH < 65535) ? 16'(MAX_TEXT_LENGTH) : 16'hFFFF;

    localparam int unsigned KEYWORD_MAX_CHARS = 9;
    localparam int unsigned WORD_COUNT_W = $clog2(KEYWORD_MAX_CHARS + 2);
    localparam int unsigned KEY_W = KEYWORD_MAX_CHARS * 8;
    localparam int unsigned KEYWORD_COUNT = 23;

    localparam int unsigned OUT_FIFO_DEPTH = 4;

    localparam logic [2:0] KIND_TEXT    = 3'd0;
    localparam logic [2:0] KIND_STRING  = 3'd1;
    localparam logic [2:0] KIND_COMMENT = 3'd2;
    localparam logic [2:0] KIND_NUMBER  = 3'd3;
    localparam logic [2:0] KIND_IDENT   = 3'd4;
    localparam logic [2:0] KIND_KEYWORD = 3'd5;
    localparam logic [2:0] KIND_OPER    = 3'd6;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } slx_in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        run_end;
    } slx_out_t;

    typedef logic [KEYWORD_MAX_CHARS-1:0][7:0] word_chars_t;

    // Keywords are right-justified, the last character in the low byte.
    localparam logic [KEY_W-1:0] KEYWORD_TABLE [KEYWORD_COUNT] = '{
        KEY_W'("int"),      KEY_W'("char"),      KEY_W'("bool"),    KEY_W'("void"),
        KEY_W'("return"),   KEY_W'("if"),        KEY_W'("else"),    KEY_W'("for"),
        KEY_W'("while"),    KEY_W'("class"),     KEY_W'("struct"),  KEY_W'("namespace"),
        KEY_W'("using"),    KEY_W'("public"),    KEY_W'("private"), KEY_W'("protected"),
        KEY_W'("virtual"),  KEY_W'("static"),    KEY_W'("const"),   KEY_W'("auto"),
        KEY_W'("template"), KEY_W'("typename"),  KEY_W'("sizeof")
    };

    // A word is a keyword when its stored characters, packed in the same way
    // as the table, equal one entry. Words longer than the store never match.
    function automatic logic is_keyword(input word_chars_t chars,
                                        input logic [WORD_COUNT_W-1:0] count);
        logic [KEY_W-1:0] key;
        logic             hit;
        key = '0;
        hit = 1'b0;
        for (int j = 0; j < KEYWORD_MAX_CHARS; j++) begin
            if (j < int'(count)) begin
                key = {key[KEY_W-9:0], chars[j]};
            end
        end
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (key == KEYWORD_TABLE[i]) begin
                hit = 1'b1;
            end
        end
        return hit && (count <= WORD_COUNT_W'(KEYWORD_MAX_CHARS));
    endfunction

endpackage

`default_nettype wire

### hw/rtl/slx_out_fifo.sv
// ----------------------------------------------------------------------------
// Source code lexer result queue
// Small queue that takes up to two tokens per cycle and hands out one per
// cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slx_out_fifo #(
    parameter int unsigned DEPTH = slx_pkg::OUT_FIFO_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [1:0]       push_cnt,
    input  wire slx_pkg::slx_out_t push0_data,
    input  wire slx_pkg::slx_out_t push1_data,
    output logic                  room_two,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output slx_pkg::slx_out_t     m_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    slx_pkg::slx_out_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign pop          = m_valid && m_ready;
    assign m_valid      = (count_reg != '0);
    assign m_data       = mem_reg[rd_ptr_reg];
    assign room_two     = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push_cnt == 2'd1) begin
            wr_ptr_next = wr_ptr_plus1;
        end else if (push_cnt == 2'd2) begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0_data;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/source_code_lexer.sv
// ----------------------------------------------------------------------------
// Source code lexer
// Streaming C-like tokenizer that turns a byte stream into tokens.
// ----------------------------------------------------------------------------
// The s_ channel carries one byte of text per transaction, with final_char set
// on the last byte. The m_ channel carries tokens as kind, start offset and
// length; run_end marks the last token caused by one byte.
// A byte is taken in the cycle it is offered whenever the result queue has room
// for two tokens, so the input sustains one byte per cycle. Each byte yields
// zero, one or two tokens; each token is written into the result queue when the
// byte that caused it is taken and is offered on m_valid from there. The result
// channel drains one token per cycle while m_ready is high, so a run of bytes
// that each produce two tokens is limited by the output.
// When the receiver stalls, tokens collect in the result queue and s_ready
// drops once fewer than two free entries remain.
// Reset clears the lexer, the byte position, the queue and the plain-text
// register. The register is written through cfg_we and takes effect on the
// next byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module source_code_lexer #(
    parameter int unsigned OUT_FIFO_DEPTH = slx_pkg::OUT_FIFO_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire slx_pkg::slx_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output slx_pkg::slx_out_t      m_data
);

    localparam int unsigned CW = slx_pkg::WORD_COUNT_W;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_STRING  = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_WORD    = 3'd4;
    localparam logic [2:0] MODE_SLASH   = 3'd5;

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_DOT       = 8'h2E;

    logic                 plain_reg;
    logic [2:0]           mode_reg, mode_next;
    logic                 quote_single_reg, quote_single_next;
    logic                 escape_reg, escape_next;
    logic [15:0]          pos_reg, pos_next;
    logic [15:0]          begin_reg, begin_next;
    slx_pkg::word_chars_t chars_reg, chars_next;
    logic [CW-1:0]        count_reg, count_next;

    logic                 accept;
    logic [7:0]           c;
    logic                 fin;
    logic [16:0]          pos_plus1;
    logic                 do_start;
    logic                 first_v, second_v;
    slx_pkg::slx_out_t    first_tok, second_tok;
    slx_pkg::slx_out_t    push0_data, push1_data;
    logic [1:0]           push_cnt;
    logic                 room_two;

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic logic is_num_char(input logic [7:0] ch);
        return is_digit(ch) || ch == CH_DOT || ch == "x" || ch == "X" ||
               (ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F");
    endfunction

    function automatic logic [15:0] token_len(input logic [16:0] end_pos,
                                              input logic [15:0] begin_pos);
        logic [15:0] e;
        e = (end_pos > {1'b0, slx_pkg::POS_LIMIT}) ? slx_pkg::POS_LIMIT : end_pos[15:0];
        return (e > begin_pos) ? e - begin_pos : 16'd1;
    endfunction

    function automatic slx_pkg::slx_out_t make_tok(input logic [2:0] kind,
                                                   input logic [15:0] start,
                                                   input logic [15:0] len);
        slx_pkg::slx_out_t t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.run_end      = 1'b0;
        return t;
    endfunction

    assign accept    = s_valid && s_ready;
    assign s_ready   = room_two;
    assign c         = s_data.char_code;
    assign fin       = s_data.final_char;
    assign pos_plus1 = {1'b0, pos_reg} + 17'd1;

    always_comb begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        escape_next       = escape_reg;
        begin_next        = begin_reg;
        chars_next        = chars_reg;
        count_next        = count_reg;
        do_start          = 1'b0;
        first_v           = 1'b0;
        second_v          = 1'b0;
        first_tok         = make_tok(slx_pkg::KIND_OPER, begin_reg, 16'd1);
        second_tok        = make_tok(slx_pkg::KIND_OPER, pos_reg, 16'd1);

        if (plain_reg) begin
            if (fin) begin
                second_v   = 1'b1;
                second_tok = make_tok(slx_pkg::KIND_TEXT, 16'd0,
                                      token_len(pos_plus1, 16'd0));
            end
        end else begin
            unique case (mode_reg)
                MODE_STRING: begin
                    if (escape_reg) begin
                        escape_next = 1'b0;
                    end else if (c == CH_BACKSLASH) begin
                        escape_next = 1'b1;
                    end else if (c == (quote_single_reg ? CH_SQUOTE : CH_DQUOTE)) begin
                        first_v   = 1'b1;
                        first_tok = make_tok(slx_pkg::KIND_STRING, begin_reg,
                                             token_len(pos_plus1, begin_reg));
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        first_v   = 1'b1;
                        first_tok = make_tok(slx_pkg::KIND_COMMENT, begin_reg,
                                             token_len({1'b0, pos_reg}, begin_reg));
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (!is_num_char(c)) begin
                        first_v   = 1'b1;
                        first_tok = make_tok(slx_pkg::KIND_NUMBER, begin_reg,
                                             token_len({1'b0, pos_reg}, begin_reg));
                        do_start  = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDERLINE) begin
                        if (count_reg < CW'(slx_pkg::KEYWORD_MAX_CHARS)) begin
                            chars_next[count_reg] = c;
                        end
                        if (count_reg <= CW'(slx_pkg::KEYWORD_MAX_CHARS)) begin
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        first_v   = 1'b1;
                        first_tok = make_tok(
                            slx_pkg::is_keyword(chars_reg, count_reg) ?
                                slx_pkg::KIND_KEYWORD : slx_pkg::KIND_IDENT,
                            begin_reg, token_len({1'b0, pos_reg}, begin_reg));
                        do_start  = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        first_v   = 1'b1;
                        first_tok = make_tok(slx_pkg::KIND_OPER, begin_reg, 16'd1);
                        do_start  = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start) begin
                mode_next = MODE_IDLE;
                if (!is_space(c)) begin
                    begin_next = pos_reg;
                    if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                        mode_next         = MODE_STRING;
                        quote_single_next = (c == CH_SQUOTE);
                        escape_next       = 1'b0;
                    end else if (c == CH_SLASH) begin
                        mode_next = MODE_SLASH;
                    end else if (is_digit(c)) begin
                        mode_next = MODE_NUMBER;
                    end else if (is_alpha(c) || c == CH_UNDERLINE) begin
                        mode_next     = MODE_WORD;
                        chars_next[0] = c;
                        count_next    = CW'(1);
                    end else begin
                        second_v   = 1'b1;
                        second_tok = make_tok(slx_pkg::KIND_OPER, pos_reg, 16'd1);
                    end
                end
            end

            if (fin && mode_next != MODE_IDLE) begin
                second_v = 1'b1;
                unique case (mode_next)
                    MODE_STRING: begin
                        second_tok = make_tok(slx_pkg::KIND_STRING, begin_next,
                                              token_len(pos_plus1, begin_next));
                    end
                    MODE_COMMENT: begin
                        second_tok = make_tok(slx_pkg::KIND_COMMENT, begin_next,
                                              token_len(pos_plus1, begin_next));
                    end
                    MODE_NUMBER: begin
                        second_tok = make_tok(slx_pkg::KIND_NUMBER, begin_next,
                                              token_len(pos_plus1, begin_next));
                    end
                    MODE_WORD: begin
                        second_tok = make_tok(
                            slx_pkg::is_keyword(chars_next, count_next) ?
                                slx_pkg::KIND_KEYWORD : slx_pkg::KIND_IDENT,
                            begin_next, token_len(pos_plus1, begin_next));
                    end
                    default: begin
                        second_tok = make_tok(slx_pkg::KIND_OPER, begin_next, 16'd1);
                    end
                endcase
            end
        end

        if (fin) begin
            mode_next         = MODE_IDLE;
            quote_single_next = 1'b0;
            escape_next       = 1'b0;
            begin_next        = 16'd0;
            count_next        = '0;
            pos_next          = 16'd0;
        end else begin
            pos_next = (pos_plus1 > {1'b0, slx_pkg::POS_LIMIT}) ?
                       slx_pkg::POS_LIMIT : pos_plus1[15:0];
        end
    end

    always_comb begin
        push0_data = first_v ? first_tok : second_tok;
        push1_data = second_tok;
        push0_data.run_end = !(first_v && second_v);
        push1_data.run_end = 1'b1;
        if (!accept) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = {1'b0, first_v} + {1'b0, second_v};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plain_reg        <= 1'b0;
            mode_reg         <= MODE_IDLE;
            quote_single_reg <= 1'b0;
            escape_reg       <= 1'b0;
            pos_reg          <= 16'd0;
            begin_reg        <= 16'd0;
            count_reg        <= '0;
        end else begin
            if (cfg_we) begin
                plain_reg <= cfg_wdata;
            end
            if (accept) begin
                mode_reg         <= mode_next;
                quote_single_reg <= quote_single_next;
                escape_reg       <= escape_next;
                pos_reg          <= pos_next;
                begin_reg        <= begin_next;
                count_reg        <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            chars_reg <= chars_next;
        end
    end

    slx_out_fifo #(
        .DEPTH(OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0_data(push0_data),
        .push1_data(push1_data),
        .room_two  (room_two),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### hw/rtl/slx_checker.sv
// ----------------------------------------------------------------------------
// Source code lexer port checker
// Checks on the ports of the lexer over time, attached to it by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "source_code_lexer_assert.svh"

module slx_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire slx_pkg::slx_out_t m_data
);

    logic m_stall;
    logic text_tok;
    logic text_ok;
    logic oper_tok;

    assign m_stall  = m_valid && !m_ready;
    assign text_tok = m_valid && (m_data.token_kind == slx_pkg::KIND_TEXT);
    assign text_ok  = (m_data.token_start == 16'd0) && m_data.run_end;
    assign oper_tok = m_valid && (m_data.token_kind == slx_pkg::KIND_OPER);

    `SLX_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_stall, m_valid && $stable(m_data))
    `SLX_ASSERT_SAME(a_length_nonzero, aclk, aresetn, m_valid, m_data.token_length != 16'd0)
    `SLX_ASSERT_SAME(a_text_whole, aclk, aresetn, text_tok, text_ok)
    `SLX_ASSERT_SAME(a_oper_one_byte, aclk, aresetn, oper_tok, m_data.token_length == 16'd1)

endmodule

bind source_code_lexer slx_checker u_slx_checker (.*);

`default_nettype wire
